/* rtl/tpuv_pkg.sv */
// ----------------------------------------------------------------------------
// tpuv_pkg
// Types, constants and the arctangent table for the texture projection unit.
// ----------------------------------------------------------------------------
package tpuv_pkg;

    localparam int W_D  = 34;   // offset operand, covers negation of a 33-bit difference
    localparam int W_XY = 38;   // CORDIC x/y with growth
    localparam int W_Z  = 35;   // angle in 2^-32 turns with headroom

    localparam logic signed [W_Z-1:0] TURN_HALF    = 35'sh0_8000_0000;
    localparam logic signed [W_Z-1:0] TURN_QUARTER = 35'sh0_4000_0000;

    typedef enum logic [1:0] {
        MODE_PLANAR = 2'd0,
        MODE_CYL    = 2'd1,
        MODE_SPHERE = 2'd2,
        MODE_UV     = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        AXIS_X   = 2'd0,
        AXIS_Y   = 2'd1,
        AXIS_Z   = 2'd2,
        AXIS_BAD = 2'd3
    } axis_t;

    typedef enum logic [2:0] {
        REG_MODE   = 3'd0,
        REG_AXIS   = 3'd1,
        REG_CX     = 3'd2,
        REG_CY     = 3'd3,
        REG_CZ     = 3'd4,
        REG_ISX    = 3'd5,
        REG_ISY    = 3'd6,
        REG_ISZ    = 3'd7
    } reg_idx_t;

    typedef enum logic [1:0] {
        KIND_PLANAR = 2'd0,
        KIND_CYL    = 2'd1,
        KIND_UNSUP  = 2'd2
    } kind_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } in_t;

    typedef struct packed {
        logic signed [31:0] tex_u;
        logic signed [31:0] tex_v;
        logic               mode_unsupported;
    } out_t;

    typedef struct packed {
        kind_t                  kind;
        logic                   u_zero;
        logic                   v_zero;
        logic                   spec;
        logic signed [W_Z-1:0]  spec_h;
    } ctrl_t;

    typedef struct packed {
        logic signed [W_D-1:0]  a;
        logic signed [W_D-1:0]  c;
        logic signed [W_D-1:0]  su;
        logic signed [W_D-1:0]  sv;
        logic [31:0]            iu;
        logic [31:0]            iv;
        ctrl_t                  ctrl;
    } front_t;

    function automatic logic signed [W_D-1:0] neg34(input logic signed [32:0] d);
        logic signed [W_D-1:0] e;
        e = W_D'(d);
        return -e;
    endfunction

    // atan(2^-i) in 2^-32 turns
    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] r;
        case (i)
            5'd0:    r = 32'h20000000;
            5'd1:    r = 32'h12E4051E;
            5'd2:    r = 32'h09FB385B;
            5'd3:    r = 32'h051111D4;
            5'd4:    r = 32'h028B0D43;
            5'd5:    r = 32'h0145D7E1;
            5'd6:    r = 32'h00A2F61E;
            5'd7:    r = 32'h00517C55;
            5'd8:    r = 32'h0028BE53;
            5'd9:    r = 32'h00145F2F;
            5'd10:   r = 32'h000A2F98;
            5'd11:   r = 32'h000517CC;
            5'd12:   r = 32'h00028BE6;
            5'd13:   r = 32'h000145F3;
            5'd14:   r = 32'h0000A2FA;
            5'd15:   r = 32'h0000517D;
            5'd16:   r = 32'h000028BE;
            5'd17:   r = 32'h0000145F;
            5'd18:   r = 32'h00000A30;
            5'd19:   r = 32'h00000518;
            5'd20:   r = 32'h0000028C;
            5'd21:   r = 32'h00000146;
            5'd22:   r = 32'h000000A3;
            5'd23:   r = 32'h00000051;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage

/* rtl/texture_projection_uv_unit.sv */
// ----------------------------------------------------------------------------
// texture_projection_uv_unit
// Planar / cylindrical texture projection of vertex positions to Q-format u,v.
// ----------------------------------------------------------------------------
// Pipeline: front register, CORDIC pre-rotation register, CORDIC step registers, output register.
// Throughput: one transaction per cycle; the CORDIC chain has one stage per step.
// The whole pipeline holds when the output register is full and not taken.
// Reset clears valid bits and loads the register reset values.
module texture_projection_uv_unit #(
    parameter int FRAC_BITS        = 16,
    parameter int ANGLE_ITERATIONS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  tpuv_pkg::in_t     in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output tpuv_pkg::out_t    out_data,
    input  logic              cfg_wr_en,
    input  logic [2:0]        cfg_index,
    input  logic [31:0]       cfg_wr_data
);

    localparam int N      = ANGLE_ITERATIONS;
    localparam int L      = N + 3;
    localparam int SDLY   = N - 2;
    localparam int WZ     = tpuv_pkg::W_Z;
    localparam logic [31:0] ONE = 32'(1) << FRAC_BITS;
    localparam logic signed [35:0] FULL = 36'sh1_0000_0000;
    localparam logic signed [35:0] URND = 36'(1) << (31 - FRAC_BITS);

    tpuv_pkg::mode_t    mode_reg;
    tpuv_pkg::axis_t    axis_reg;
    logic signed [31:0] cx_reg, cy_reg, cz_reg;
    logic [31:0]        isx_reg, isy_reg, isz_reg;

    logic               vld_reg [L];
    logic               en;

    tpuv_pkg::front_t   front;
    logic signed [31:0] su_res, sv_res;
    logic signed [WZ-1:0] cz;

    logic signed [31:0] su_dly_reg [SDLY];
    logic signed [31:0] sv_dly_reg [SDLY];
    tpuv_pkg::ctrl_t    ctrl_dly_reg [N+1];

    tpuv_pkg::ctrl_t    fc;
    logic signed [35:0] h;
    logic signed [35:0] t;
    logic signed [35:0] us;
    logic signed [31:0] cyl_u;
    tpuv_pkg::out_t     out_next;
    tpuv_pkg::out_t     out_reg;

    assign en       = !vld_reg[L-1] || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= tpuv_pkg::MODE_PLANAR;
            axis_reg <= tpuv_pkg::AXIS_Y;
            cx_reg   <= '0;
            cy_reg   <= '0;
            cz_reg   <= '0;
            isx_reg  <= ONE;
            isy_reg  <= ONE;
            isz_reg  <= ONE;
        end
        else if (cfg_wr_en)
        begin
            case (tpuv_pkg::reg_idx_t'(cfg_index))
                tpuv_pkg::REG_MODE: mode_reg <= tpuv_pkg::mode_t'(cfg_wr_data[1:0]);
                tpuv_pkg::REG_AXIS: axis_reg <= tpuv_pkg::axis_t'(cfg_wr_data[1:0]);
                tpuv_pkg::REG_CX:   cx_reg   <= cfg_wr_data;
                tpuv_pkg::REG_CY:   cy_reg   <= cfg_wr_data;
                tpuv_pkg::REG_CZ:   cz_reg   <= cfg_wr_data;
                tpuv_pkg::REG_ISX:  isx_reg  <= cfg_wr_data;
                tpuv_pkg::REG_ISY:  isy_reg  <= cfg_wr_data;
                tpuv_pkg::REG_ISZ:  isz_reg  <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < L; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < L; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    tpuv_front u_front (
        .clk        (clk),
        .en         (en),
        .item       (in_data),
        .mode       (mode_reg),
        .axis       (axis_reg),
        .center_x   (cx_reg),
        .center_y   (cy_reg),
        .center_z   (cz_reg),
        .inv_size_x (isx_reg),
        .inv_size_y (isy_reg),
        .inv_size_z (isz_reg),
        .front      (front)
    );

    tpuv_scale #(.FRAC_BITS(FRAC_BITS)) u_scale_u (
        .clk (clk),
        .en  (en),
        .s   (front.su),
        .inv (front.iu),
        .res (su_res)
    );

    tpuv_scale #(.FRAC_BITS(FRAC_BITS)) u_scale_v (
        .clk (clk),
        .en  (en),
        .s   (front.sv),
        .inv (front.iv),
        .res (sv_res)
    );

    tpuv_cordic #(.ITER(N)) u_cordic (
        .clk (clk),
        .en  (en),
        .a   (front.a),
        .c   (front.c),
        .z   (cz)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            su_dly_reg[0]   <= su_res;
            sv_dly_reg[0]   <= sv_res;
            for (int i = 1; i < SDLY; i++)
            begin
                su_dly_reg[i] <= su_dly_reg[i-1];
                sv_dly_reg[i] <= sv_dly_reg[i-1];
            end
            ctrl_dly_reg[0] <= front.ctrl;
            for (int i = 1; i <= N; i++)
                ctrl_dly_reg[i] <= ctrl_dly_reg[i-1];
            out_reg <= out_next;
        end
    end

    assign fc = ctrl_dly_reg[N];

    always_comb
    begin
        h = fc.spec ? 36'(fc.spec_h) : 36'(cz);
        if (h < -36'(tpuv_pkg::TURN_QUARTER))
            h = h + FULL;
        t  = FULL - h + URND;
        us = t >>> (32 - FRAC_BITS);
        if (us > 36'sh0_7FFF_FFFF)
            cyl_u = 32'sh7FFF_FFFF;
        else
            cyl_u = us[31:0];

        out_next = '0;
        case (fc.kind)
            tpuv_pkg::KIND_PLANAR:
            begin
                out_next.tex_u = fc.u_zero ? '0 : su_dly_reg[SDLY-1];
                out_next.tex_v = fc.v_zero ? '0 : sv_dly_reg[SDLY-1];
            end
            tpuv_pkg::KIND_CYL:
            begin
                out_next.tex_u = cyl_u;
                out_next.tex_v = fc.v_zero ? '0 : sv_dly_reg[SDLY-1];
            end
            default:
            begin
                out_next.mode_unsupported = 1'b1;
            end
        endcase
    end

    assign out_valid = vld_reg[L-1];
    assign out_data  = out_reg;

endmodule

/* rtl/tpuv_front.sv */
// ----------------------------------------------------------------------------
// tpuv_front
// Centre subtraction and operand selection by mode and axis (one stage).
// ----------------------------------------------------------------------------
module tpuv_front (
    input  logic                clk,
    input  logic                en,
    input  tpuv_pkg::in_t       item,
    input  tpuv_pkg::mode_t     mode,
    input  tpuv_pkg::axis_t     axis,
    input  logic signed [31:0]  center_x,
    input  logic signed [31:0]  center_y,
    input  logic signed [31:0]  center_z,
    input  logic [31:0]         inv_size_x,
    input  logic [31:0]         inv_size_y,
    input  logic [31:0]         inv_size_z,
    output tpuv_pkg::front_t    front
);

    logic signed [32:0] dx, dy, dz;
    tpuv_pkg::front_t   front_next;
    tpuv_pkg::front_t   front_reg;

    assign dx = 33'(item.pos_x) - 33'(center_x);
    assign dy = 33'(item.pos_y) - 33'(center_y);
    assign dz = 33'(item.pos_z) - 33'(center_z);

    always_comb
    begin
        front_next             = '0;
        front_next.ctrl.kind   = tpuv_pkg::KIND_UNSUP;
        case (mode)
            tpuv_pkg::MODE_PLANAR:
            begin
                front_next.ctrl.kind = tpuv_pkg::KIND_PLANAR;
                case (axis)
                    tpuv_pkg::AXIS_X:
                    begin
                        front_next.su = tpuv_pkg::W_D'(dz);
                        front_next.iu = inv_size_z;
                        front_next.sv = tpuv_pkg::neg34(dy);
                        front_next.iv = inv_size_y;
                    end
                    tpuv_pkg::AXIS_Y:
                    begin
                        front_next.su = tpuv_pkg::W_D'(dx);
                        front_next.iu = inv_size_x;
                        front_next.sv = tpuv_pkg::neg34(dz);
                        front_next.iv = inv_size_z;
                    end
                    tpuv_pkg::AXIS_Z:
                    begin
                        front_next.su = tpuv_pkg::W_D'(dx);
                        front_next.iu = inv_size_x;
                        front_next.sv = tpuv_pkg::neg34(dy);
                        front_next.iv = inv_size_y;
                    end
                    default:
                    begin
                        front_next.ctrl.u_zero = 1'b1;
                        front_next.ctrl.v_zero = 1'b1;
                    end
                endcase
            end
            tpuv_pkg::MODE_CYL:
            begin
                front_next.ctrl.kind = tpuv_pkg::KIND_CYL;
                case (axis)
                    tpuv_pkg::AXIS_X:
                    begin
                        front_next.a  = tpuv_pkg::W_D'(dz);
                        front_next.c  = tpuv_pkg::neg34(dy);
                        front_next.sv = tpuv_pkg::neg34(dx);
                        front_next.iv = inv_size_x;
                    end
                    tpuv_pkg::AXIS_Y:
                    begin
                        front_next.a  = tpuv_pkg::neg34(dx);
                        front_next.c  = tpuv_pkg::W_D'(dz);
                        front_next.sv = tpuv_pkg::neg34(dy);
                        front_next.iv = inv_size_y;
                    end
                    tpuv_pkg::AXIS_Z:
                    begin
                        front_next.a  = tpuv_pkg::neg34(dx);
                        front_next.c  = tpuv_pkg::neg34(dy);
                        front_next.sv = tpuv_pkg::neg34(dz);
                        front_next.iv = inv_size_z;
                    end
                    default:
                    begin
                        front_next.ctrl.spec   = 1'b1;
                        front_next.ctrl.v_zero = 1'b1;
                    end
                endcase
                // exact headings on the axes
                if (axis != tpuv_pkg::AXIS_BAD)
                begin
                    if (front_next.c == '0)
                    begin
                        front_next.ctrl.spec = 1'b1;
                        if (front_next.a == '0)
                            front_next.ctrl.spec_h = '0;
                        else if (front_next.a < 0)
                            front_next.ctrl.spec_h = tpuv_pkg::TURN_QUARTER;
                        else
                            front_next.ctrl.spec_h = -tpuv_pkg::TURN_QUARTER;
                    end
                    else if (front_next.a == '0)
                    begin
                        front_next.ctrl.spec   = 1'b1;
                        front_next.ctrl.spec_h = (front_next.c > 0) ? '0
                                                                    : tpuv_pkg::TURN_HALF;
                    end
                end
            end
            default:
            begin
                front_next.ctrl.kind = tpuv_pkg::KIND_UNSUP;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
            front_reg <= front_next;
    end

    assign front = front_reg;

endmodule

/* rtl/tpuv_scale.sv */
// ----------------------------------------------------------------------------
// tpuv_scale
// Three-stage round(s * inv) + 1/2 with saturation; split 34x32 multiply.
// ----------------------------------------------------------------------------
module tpuv_scale #(
    parameter int FRAC_BITS = 16
) (
    input  logic                       clk,
    input  logic                       en,
    input  logic signed [33:0]         s,
    input  logic [31:0]                inv,
    output logic signed [31:0]         res
);

    localparam logic [65:0]        ROUND = 66'(1) << (FRAC_BITS - 1);
    localparam logic signed [67:0] HALF  = 68'(1) << (FRAC_BITS - 1);
    localparam logic signed [67:0] SMAX  = 68'sh0_0000_0000_7FFF_FFFF;
    localparam logic signed [67:0] SMIN  = -68'sh0_0000_0000_8000_0000;

    logic [33:0]        mag;
    logic               neg_reg, neg2_reg;
    logic [48:0]        lo_reg, hi_reg;
    logic [65:0]        sum_reg;
    logic [65:0]        q;
    logic signed [67:0] r;
    logic signed [31:0] res_reg;
    logic signed [31:0] res_next;

    assign mag = s[33] ? 34'(-s) : 34'(s);

    always_comb
    begin
        q = sum_reg >> FRAC_BITS;
        r = 68'(q);
        if (neg2_reg)
            r = -r;
        r = r + HALF;
        if (r > SMAX)
            res_next = 32'sh7FFF_FFFF;
        else if (r < SMIN)
            res_next = -32'sh8000_0000;
        else
            res_next = r[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_reg  <= s[33];
            lo_reg   <= 49'(mag[16:0]) * 49'(inv);
            hi_reg   <= 49'(mag[33:17]) * 49'(inv);
            neg2_reg <= neg_reg;
            sum_reg  <= 66'(lo_reg) + {hi_reg, 17'b0} + ROUND;
            res_reg  <= res_next;
        end
    end

    assign res = res_reg;

endmodule

/* rtl/tpuv_cordic.sv */
// ----------------------------------------------------------------------------
// tpuv_cordic
// Vectoring CORDIC heading: quadrant pre-rotation, then one stage per step.
// ----------------------------------------------------------------------------
module tpuv_cordic #(
    parameter int ITER = 16
) (
    input  logic                               clk,
    input  logic                               en,
    input  logic signed [tpuv_pkg::W_D-1:0]    a,
    input  logic signed [tpuv_pkg::W_D-1:0]    c,
    output logic signed [tpuv_pkg::W_Z-1:0]    z
);

    localparam int WXY = tpuv_pkg::W_XY;
    localparam int WZ  = tpuv_pkg::W_Z;

    logic signed [WXY-1:0] x0, y0;
    logic signed [WZ-1:0]  z0;
    logic signed [WXY-1:0] x_reg [ITER+1];
    logic signed [WXY-1:0] y_reg [ITER+1];
    logic signed [WZ-1:0]  z_reg [ITER+1];

    always_comb
    begin
        x0 = WXY'(c);
        y0 = -WXY'(a);
        z0 = '0;
        if (x0 < 0)
        begin
            z0 = (y0 >= 0) ? tpuv_pkg::TURN_HALF : -tpuv_pkg::TURN_HALF;
            x0 = -x0;
            y0 = -y0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= x0;
            y_reg[0] <= y0;
            z_reg[0] <= z0;
        end
    end

    for (genvar i = 0; i < ITER; i++)
    begin : g_step
        logic signed [WZ-1:0] ang;
        assign ang = WZ'(tpuv_pkg::atan_turn(5'(i)));
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (y_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + ang;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - ang;
                end
            end
        end
    end

    assign z = z_reg[ITER];

endmodule

/* tb/texture_projection_uv_unit_test.sv */
// ----------------------------------------------------------------------------
// texture_projection_uv_unit_test
// Sends vertex transactions under several projection settings and checks
// every u,v result against a fixed-point planar/cylindrical predictor.
// Both sides idle and stall at random; one long output stall fills the pipe.
// ----------------------------------------------------------------------------
module texture_projection_uv_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     STEPS     = 16;
    localparam int     FRAC      = 16;
    localparam int     SETTLE    = STEPS + 8;
    localparam longint CYC_LIMIT = 400000;
    localparam longint T_QUARTER = 64'sd1073741824;
    localparam longint T_HALF    = 64'sd2147483648;
    localparam longint T_FULL    = 64'sd4294967296;

    localparam longint ATAN_TURNS [0:STEPS-1] = '{
        'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
        'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
        'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D
    };

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    tpuv_pkg::in_t     in_data;
    logic              out_valid;
    logic              out_ready;
    tpuv_pkg::out_t    out_data;
    logic              cfg_wr_en;
    logic [2:0]        cfg_index;
    logic [31:0]       cfg_wr_data;

    tpuv_pkg::mode_t   cur_mode;
    tpuv_pkg::axis_t   cur_axis;
    longint            ctr_x, ctr_y, ctr_z;
    bit [31:0]         inv_x, inv_y, inv_z;

    tpuv_pkg::out_t    uv_expected [$];
    int                fail_count;
    longint            cycle_count;
    bit                calm;
    bit                hold_request;
    int                hold_left;

    texture_projection_uv_unit uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic longint sat32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // round(d * inv) half away from zero, plus one half, saturated
    function automatic longint scaled_half(input longint d, input bit [31:0] inv);
        bit [63:0] mag;
        bit [63:0] prod;
        longint    q;
        mag  = (d < 0) ? -d : d;
        prod = mag * {32'b0, inv};
        q    = longint'((prod + (64'd1 << (FRAC - 1))) >> FRAC);
        if (d < 0)
            q = -q;
        return sat32(q + (64'sd1 <<< (FRAC - 1)));
    endfunction

    // heading in 2^-32 turns, range [-1/4, 3/4)
    function automatic longint heading_turns(input longint a, input longint c);
        longint x, y, z, nx;
        if (c == 0)
            return (a == 0) ? 0 : ((a < 0) ? T_QUARTER : -T_QUARTER);
        if (a == 0)
            return (c > 0) ? 0 : T_HALF;
        x = c;
        y = -a;
        z = 0;
        if (x < 0)
        begin
            z = (y >= 0) ? T_HALF : -T_HALF;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < STEPS; i++)
        begin
            if (y >= 0)
            begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + ATAN_TURNS[i];
            end
            else
            begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - ATAN_TURNS[i];
            end
            x = nx;
        end
        if (z < -T_QUARTER)
            z = z + T_FULL;
        return z;
    endfunction

    function automatic tpuv_pkg::out_t project_uv(input tpuv_pkg::in_t p);
        longint         dx, dy, dz, u, v, h;
        tpuv_pkg::out_t r;
        dx = longint'(p.pos_x) - ctr_x;
        dy = longint'(p.pos_y) - ctr_y;
        dz = longint'(p.pos_z) - ctr_z;
        u = 0;
        v = 0;
        h = 0;
        r.mode_unsupported = 1'b0;
        if (cur_mode == tpuv_pkg::MODE_PLANAR)
        begin
            case (cur_axis)
                tpuv_pkg::AXIS_X:
                begin
                    u = scaled_half(dz, inv_z);
                    v = scaled_half(-dy, inv_y);
                end
                tpuv_pkg::AXIS_Y:
                begin
                    u = scaled_half(dx, inv_x);
                    v = scaled_half(-dz, inv_z);
                end
                tpuv_pkg::AXIS_Z:
                begin
                    u = scaled_half(dx, inv_x);
                    v = scaled_half(-dy, inv_y);
                end
                default: ;
            endcase
        end
        else if (cur_mode == tpuv_pkg::MODE_CYL)
        begin
            case (cur_axis)
                tpuv_pkg::AXIS_X:
                begin
                    h = heading_turns(dz, -dy);
                    v = scaled_half(-dx, inv_x);
                end
                tpuv_pkg::AXIS_Y:
                begin
                    h = heading_turns(-dx, dz);
                    v = scaled_half(-dy, inv_y);
                end
                tpuv_pkg::AXIS_Z:
                begin
                    h = heading_turns(-dx, -dy);
                    v = scaled_half(-dz, inv_z);
                end
                default: ;
            endcase
            u = sat32((T_FULL - h + (64'sd1 <<< (31 - FRAC))) >>> (32 - FRAC));
        end
        else
            r.mode_unsupported = 1'b1;
        r.tex_u = u[31:0];
        r.tex_v = v[31:0];
        return r;
    endfunction

    task automatic write_reg(input tpuv_pkg::reg_idx_t idx, input logic [31:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        @(posedge clk);
    endtask

    task automatic set_projection(input tpuv_pkg::mode_t m, input tpuv_pkg::axis_t ax,
                                  input logic [31:0] cx, input logic [31:0] cy,
                                  input logic [31:0] cz, input logic [31:0] isx,
                                  input logic [31:0] isy, input logic [31:0] isz);
        write_reg(tpuv_pkg::REG_MODE, {30'b0, m});
        write_reg(tpuv_pkg::REG_AXIS, {30'b0, ax});
        write_reg(tpuv_pkg::REG_CX, cx);
        write_reg(tpuv_pkg::REG_CY, cy);
        write_reg(tpuv_pkg::REG_CZ, cz);
        write_reg(tpuv_pkg::REG_ISX, isx);
        write_reg(tpuv_pkg::REG_ISY, isy);
        write_reg(tpuv_pkg::REG_ISZ, isz);
        cfg_wr_en <= 1'b0;
        cur_mode = m;
        cur_axis = ax;
        ctr_x = longint'(signed'(cx));
        ctr_y = longint'(signed'(cy));
        ctr_z = longint'(signed'(cz));
        inv_x = isx;
        inv_y = isy;
        inv_z = isz;
        @(posedge clk);
    endtask

    task automatic send_vertex(input logic [31:0] x, input logic [31:0] y,
                               input logic [31:0] z);
        tpuv_pkg::in_t p;
        p.pos_x = x;
        p.pos_y = y;
        p.pos_z = z;
        while (!calm && $urandom_range(99) < 19)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_data  <= p;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        uv_expected.insert(uv_expected.size(), project_uv(p));
    endtask

    task automatic drain_pipe();
        in_valid <= 1'b0;
        while (uv_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_coord(input longint c);
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(3))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h0;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            1, 2, 3: return c[31:0] + $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
            4: return c[31:0];
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_inv();
        case ($urandom_range(7))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return 32'h0001_0000;
            3: return $urandom_range(0, 32'h0004_0000);
            default: return $urandom;
        endcase
    endfunction

    task automatic test_reset_defaults();
        send_vertex(32'h0001_0000, 32'h0002_0000, 32'hFFFF_8000);
        send_vertex(32'h7FFF_FFFF, 32'h0, 32'h8000_0000);
        drain_pipe();
    endtask

    task automatic test_planar_axes();
        set_projection(tpuv_pkg::MODE_PLANAR, tpuv_pkg::AXIS_X,
                       32'h0001_0000, 32'hFFFF_0000, 32'h0,
                       32'h0000_8000, 32'h0002_0000, 32'h0001_0000);
        send_vertex(32'h0003_0000, 32'h0000_0001, 32'hFFFF_FFFF);
        send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        drain_pipe();
        set_projection(tpuv_pkg::MODE_PLANAR, tpuv_pkg::AXIS_Z,
                       32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                       32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
        send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
        drain_pipe();
    endtask

    task automatic test_cylinder_headings();
        tpuv_pkg::axis_t ax;
        for (int k = 0; k < 3; k++)
        begin
            ax = tpuv_pkg::axis_t'(k);
            set_projection(tpuv_pkg::MODE_CYL, ax, 32'h0, 32'h0, 32'h0,
                           32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
            send_vertex(32'h0, 32'h0, 32'h0);
            send_vertex(32'h0001_0000, 32'h0, 32'h0);
            send_vertex(32'h0, 32'hFFFF_0000, 32'h0);
            send_vertex(32'h0, 32'h0, 32'h0001_0000);
            send_vertex(32'hFFFF_0000, 32'h0001_0000, 32'hFFFF_0000);
            drain_pipe();
        end
    endtask

    task automatic test_odd_settings();
        set_projection(tpuv_pkg::MODE_PLANAR, tpuv_pkg::AXIS_BAD, 32'h0, 32'h0, 32'h0,
                       32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        send_vertex(32'h0005_0000, 32'h0006_0000, 32'h0007_0000);
        drain_pipe();
        set_projection(tpuv_pkg::MODE_CYL, tpuv_pkg::AXIS_BAD, 32'h0, 32'h0, 32'h0,
                       32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        send_vertex(32'h0005_0000, 32'h0006_0000, 32'h0007_0000);
        drain_pipe();
        set_projection(tpuv_pkg::MODE_SPHERE, tpuv_pkg::AXIS_Y, 32'h0, 32'h0, 32'h0,
                       32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        send_vertex(32'h0005_0000, 32'h0006_0000, 32'h0007_0000);
        drain_pipe();
        set_projection(tpuv_pkg::MODE_UV, tpuv_pkg::AXIS_Z, 32'h0, 32'h0, 32'h0,
                       32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        send_vertex(32'h0005_0000, 32'h0006_0000, 32'h0007_0000);
        drain_pipe();
    endtask

    task automatic random_phase(input int count, input bit with_hold);
        set_projection(($urandom_range(9) < 8) ? tpuv_pkg::mode_t'($urandom_range(1))
                                               : tpuv_pkg::mode_t'($urandom_range(3)),
                       ($urandom_range(19) == 0) ? tpuv_pkg::AXIS_BAD
                                                 : tpuv_pkg::axis_t'($urandom_range(2)),
                       pick_coord(0), pick_coord(0), pick_coord(0),
                       pick_inv(), pick_inv(), pick_inv());
        if (with_hold)
            hold_request = 1'b1;
        for (int n = 0; n < count; n++)
            send_vertex(pick_coord(ctr_x), pick_coord(ctr_y), pick_coord(ctr_z));
        drain_pipe();
    endtask

    task automatic test_stall_fill();
        calm = 1'b1;
        random_phase(60, 1'b1);
        calm = 1'b0;
    endtask

    task automatic test_random_mix();
        for (int ph = 0; ph < 14; ph++)
        begin
            calm = (ph == 5);
            random_phase(90, 1'b0);
        end
        calm = 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left = 300;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= calm || ($urandom_range(99) >= 19);
    end

    always @(posedge clk)
    begin
        tpuv_pkg::out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (uv_expected.size() == 0)
            begin
                $error("unexpected transaction: u=%h v=%h flag=%b",
                       out_data.tex_u, out_data.tex_v, out_data.mode_unsupported);
                fail_count++;
            end
            else
            begin
                want = uv_expected.pop_front();
                if (out_data.tex_u !== want.tex_u)
                begin
                    $error("tex_u expected %h actual %h", want.tex_u, out_data.tex_u);
                    fail_count++;
                end
                if (out_data.tex_v !== want.tex_v)
                begin
                    $error("tex_v expected %h actual %h", want.tex_v, out_data.tex_v);
                    fail_count++;
                end
                if (out_data.mode_unsupported !== want.mode_unsupported)
                begin
                    $error("mode_unsupported expected %b actual %b",
                           want.mode_unsupported, out_data.mode_unsupported);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYC_LIMIT)
        begin
            $display("texture_projection_uv_unit test failed");
            $finish;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        out_ready    = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = '0;
        cfg_wr_data  = '0;
        fail_count   = 0;
        cycle_count  = 0;
        calm         = 1'b0;
        hold_request = 1'b0;
        hold_left    = 0;
        cur_mode     = tpuv_pkg::MODE_PLANAR;
        cur_axis     = tpuv_pkg::AXIS_Y;
        ctr_x        = 0;
        ctr_y        = 0;
        ctr_z        = 0;
        inv_x        = 32'h0001_0000;
        inv_y        = 32'h0001_0000;
        inv_z        = 32'h0001_0000;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_planar_axes();
        test_cylinder_headings();
        test_odd_settings();
        test_stall_fill();
        test_random_mix();

        if (fail_count == 0 && uv_expected.size() == 0)
            $display("texture_projection_uv_unit test passed");
        else
            $display("texture_projection_uv_unit test failed");
        $finish;
    end

endmodule
